[rtl/sdn_pkg.sv]
// Shared types and constants for the scalar dissipation unit.
`timescale 1ns / 1ps
`default_nettype none
package sdn_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DIV_W         = 64;   // dividend and quotient width
	localparam int DVS_W         = 33;   // divisor width
	localparam int MUL_W         = 64;   // multiplier operand width
	localparam int CHI_W         = 48;
	localparam int IN_W          = 144;

	typedef enum logic [22:0] {
		ST_IDLE = 23'h000001,
		ST_DQ   = 23'h000002,
		ST_WQ   = 23'h000004,
		ST_DD   = 23'h000008,
		ST_WD   = 23'h000010,
		ST_SEL  = 23'h000020,
		ST_S2   = 23'h000040,
		ST_WS2  = 23'h000080,
		ST_S1   = 23'h000100,
		ST_WS1  = 23'h000200,
		ST_W1   = 23'h000400,
		ST_WW1  = 23'h000800,
		ST_P1   = 23'h001000,
		ST_WP1  = 23'h002000,
		ST_P2   = 23'h004000,
		ST_WP2  = 23'h008000,
		ST_EM   = 23'h010000,
		ST_SQ   = 23'h020000,
		ST_WSQ  = 23'h040000,
		ST_TT   = 23'h080000,
		ST_WT   = 23'h100000,
		ST_OUT  = 23'h200000,
		ST_FIN  = 23'h400000
	} state_t;

	typedef enum logic [2:0] {
		DS_Q1,
		DS_D,
		DS_S2,
		DS_S1,
		DS_W1
	} div_sel_t;

	typedef enum logic [1:0] {
		MS_P1,
		MS_P2,
		MS_SQ,
		MS_T
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     dfault;
		logic     out_load;
		logic     second;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic zero_div;
		logic last;
		logic h2_zero;
		logic first_bad;
		logic emit_bad;
		logic seen_zero;
		logic seen_two;
		logic div_busy;
		logic div_done;
		logic mul_busy;
		logic mul_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

[rtl/sdn_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sdn_div
	import sdn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIV_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] n_q;
	logic [DVS_W-1:0] d_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, n_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			n_q   <= {n_q[DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = n_q;

endmodule
`default_nettype wire

[rtl/sdn_mul.sv]
// Shift-and-add multiplier, one operand bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sdn_mul
	import sdn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [MUL_W-1:0]   op_a,
	input  wire logic [MUL_W-1:0]   op_b,
	output logic                    busy,
	output logic                    done,
	output logic [2*MUL_W-1:0]      product
);

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [2*MUL_W-1:0] acc_q;
	logic [2*MUL_W-1:0] a_q;
	logic [MUL_W-1:0]   b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {{MUL_W{1'b0}}, op_a};
			b_q   <= op_b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[2*MUL_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

[rtl/sdn_ctrl.sv]
// Sequencer for the per-point divide, multiply and emit steps.
`timescale 1ns / 1ps
`default_nettype none
module sdn_ctrl
	import sdn_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   second_q, second_d;
	state_t after_s2;

	assign after_s2 = (sts.seen_two && !sts.first_bad) ? ST_S1 : ST_EM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		second_d      = second_q;
		cmd           = '0;
		cmd.div_sel   = DS_Q1;
		cmd.mul_sel   = MS_P1;
		cmd.second    = second_q;
		s_tready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				second_d = 1'b0;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DQ;
				end
			end
			ST_DQ: begin
				if (sts.zero_div) begin
					cmd.dfault = 1'b1;
					state_d    = ST_SEL;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_Q1;
					state_d       = ST_WQ;
				end
			end
			ST_WQ: if (sts.div_done) state_d = ST_DD;
			ST_DD: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_D;
				state_d       = ST_WD;
			end
			ST_WD: if (sts.div_done) state_d = ST_SEL;
			ST_SEL: begin
				if (sts.seen_zero) begin
					state_d = sts.last ? ST_OUT : ST_FIN;
				end else if (!sts.h2_zero) begin
					state_d = ST_S2;
				end else begin
					state_d = after_s2;
				end
			end
			ST_S2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_S2;
				state_d       = ST_WS2;
			end
			ST_WS2: if (sts.div_done) state_d = after_s2;
			ST_S1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_S1;
				state_d       = ST_WS1;
			end
			ST_WS1: if (sts.div_done) state_d = ST_W1;
			ST_W1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_W1;
				state_d       = ST_WW1;
			end
			ST_WW1: if (sts.div_done) state_d = ST_P1;
			ST_P1: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_P1;
				state_d       = ST_WP1;
			end
			ST_WP1: if (sts.mul_done) state_d = ST_P2;
			ST_P2: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_P2;
				state_d       = ST_WP2;
			end
			ST_WP2: if (sts.mul_done) state_d = ST_EM;
			ST_EM: state_d = sts.emit_bad ? ST_OUT : ST_SQ;
			ST_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_SQ;
				state_d       = ST_WSQ;
			end
			ST_WSQ: if (sts.mul_done) state_d = ST_TT;
			ST_TT: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_T;
				state_d       = ST_WT;
			end
			ST_WT: if (sts.mul_done) state_d = ST_OUT;
			ST_OUT: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					if (!sts.seen_zero && !second_q && sts.last) begin
						second_d = 1'b1;
						state_d  = ST_EM;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				second_d   = 1'b0;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier started while busy");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("output register overwritten");
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.second) |-> sts.last)
		else $error("second result without last point");

endmodule
`default_nettype wire

[rtl/sdn_dp.sv]
// Datapath: line state, shared divider and multiplier, output register.
`timescale 1ns / 1ps
`default_nettype none
module sdn_dp
	import sdn_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cmd_t            cmd,
	output sts_t                 sts,
	input  wire logic [IN_W-1:0] s_tdata,
	input  wire logic            s_tlast,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [CHI_W-1:0]     m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	localparam int SW = 25 + FRAC_BITS;  // slope magnitude width
	localparam int GW = SW + 2;          // gradient magnitude width
	localparam logic [63:0] CHI_HALF = 64'h0000_7FFF_FFFF_FFFF;

	function automatic logic [31:0] clamp32(input logic [DIV_W-1:0] v);
		return (v[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [63:0] sat_shr(input logic [2*MUL_W-1:0] p, input int s);
		logic [2*MUL_W-1:0] sh;
		sh = p >> s;
		return (sh[2*MUL_W-1:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : sh[63:0];
	endfunction

	// current point
	logic [31:0] x_q, k_q, cp_q, rho_q;
	logic [15:0] z_q;
	logic        last_q;
	// line state
	logic [31:0] older_pos_q, prev_pos_q, pend_d_q;
	logic [15:0] older_mix_q, prev_mix_q;
	logic        pend_f_q;
	logic [1:0]  seen_q;
	// work registers
	logic [31:0]   q1_q, dcur_q;
	logic          fcur_q;
	logic [SW-1:0] s1mag_q, s2mag_q;
	logic          s1neg_q, s2neg_q;
	logic [32:0]   w1_q;
	logic [SW:0]   p1_q, p2_q;
	logic [63:0]   sq_q, t_q;
	div_sel_t      div_sel_q;
	mul_sel_t      mul_sel_q;
	// output
	logic             out_v_q;
	logic [CHI_W-1:0] chi_q;
	logic             eol_q, fault_q;

	logic [31:0]        h1, h2;
	logic [16:0]        dz1, dz2, dz1n, dz2n;
	logic [15:0]        dz1mag, dz2mag;
	logic [32:0]        w2;
	logic [GW-1:0]      p1s, p2s, gsum, gmag, emit_g;
	logic [31:0]        emit_d;
	logic               first_bad, emit_bad;
	logic [DIV_W-1:0]   div_a, quo;
	logic [DVS_W-1:0]   div_b;
	logic               div_busy, div_done;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod;
	logic               mul_busy, mul_done;
	logic [CHI_W-1:0]   chi_calc;

	assign h2     = x_q - prev_pos_q;
	assign h1     = prev_pos_q - older_pos_q;
	assign dz2    = {1'b0, z_q} - {1'b0, prev_mix_q};
	assign dz1    = {1'b0, prev_mix_q} - {1'b0, older_mix_q};
	assign dz2n   = -dz2;
	assign dz1n   = -dz1;
	assign dz2mag = dz2[16] ? dz2n[15:0] : dz2[15:0];
	assign dz1mag = dz1[16] ? dz1n[15:0] : dz1[15:0];
	assign w2     = 33'h1_0000_0000 - w1_q;

	assign p1s    = s1neg_q ? -GW'(p1_q) : GW'(p1_q);
	assign p2s    = s2neg_q ? -GW'(p2_q) : GW'(p2_q);
	assign gsum   = p1s + p2s;
	assign gmag   = gsum[GW-1] ? -gsum : gsum;

	assign first_bad = pend_f_q || (h2 == '0) || ((seen_q == 2'd2) && (h1 == '0));
	assign emit_bad  = cmd.second ? (fcur_q || (h2 == '0)) : first_bad;
	assign emit_d    = cmd.second ? dcur_q : pend_d_q;
	assign emit_g    = (cmd.second || (seen_q != 2'd2)) ? GW'(s2mag_q) : gmag;
	assign chi_calc  = (t_q > CHI_HALF) ? '1 : {t_q[CHI_W-2:0], 1'b0};

	always_comb begin
		div_a = '0;
		div_b = '0;
		case (cmd.div_sel)
			DS_Q1: begin
				div_a = DIV_W'(k_q) << FRAC_BITS;
				div_b = DVS_W'(rho_q);
			end
			DS_D: begin
				div_a = DIV_W'(q1_q) << FRAC_BITS;
				div_b = DVS_W'(cp_q);
			end
			DS_S2: begin
				div_a = DIV_W'(dz2mag) << (9 + FRAC_BITS);
				div_b = DVS_W'(h2);
			end
			DS_S1: begin
				div_a = DIV_W'(dz1mag) << (9 + FRAC_BITS);
				div_b = DVS_W'(h1);
			end
			DS_W1: begin
				div_a = {h2, 32'h0};
				div_b = DVS_W'(h1) + DVS_W'(h2);
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MS_P1: begin
				mul_a = MUL_W'(w1_q);
				mul_b = MUL_W'(s1mag_q);
			end
			MS_P2: begin
				mul_a = MUL_W'(w2);
				mul_b = MUL_W'(s2mag_q);
			end
			MS_SQ: begin
				mul_a = MUL_W'(emit_g);
				mul_b = MUL_W'(emit_g);
			end
			MS_T: begin
				mul_a = sq_q;
				mul_b = MUL_W'(emit_d);
			end
			default: ;
		endcase
	end

	sdn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	sdn_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (prod)
	);

	// line state: clear after the last point, otherwise shift the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_pos_q <= '0;
			prev_pos_q  <= '0;
			older_mix_q <= '0;
			prev_mix_q  <= '0;
			pend_d_q    <= '0;
			pend_f_q    <= 1'b0;
			seen_q      <= '0;
		end else if (cmd.finish) begin
			if (last_q) begin
				older_pos_q <= '0;
				prev_pos_q  <= '0;
				older_mix_q <= '0;
				prev_mix_q  <= '0;
				pend_d_q    <= '0;
				pend_f_q    <= 1'b0;
				seen_q      <= '0;
			end else begin
				older_pos_q <= prev_pos_q;
				prev_pos_q  <= x_q;
				older_mix_q <= prev_mix_q;
				prev_mix_q  <= z_q;
				pend_d_q    <= dcur_q;
				pend_f_q    <= fcur_q;
				if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= s_tdata[31:0];
			z_q    <= s_tdata[47:32];
			k_q    <= s_tdata[79:48];
			cp_q   <= s_tdata[111:80];
			rho_q  <= s_tdata[143:112];
			last_q <= s_tlast;
			fcur_q <= 1'b0;
		end
		if (cmd.dfault) begin
			dcur_q <= 32'hFFFF_FFFF;
			fcur_q <= 1'b1;
		end
		if (cmd.div_start) div_sel_q <= cmd.div_sel;
		if (cmd.mul_start) mul_sel_q <= cmd.mul_sel;
		if (div_done) begin
			case (div_sel_q)
				DS_Q1: q1_q <= clamp32(quo);
				DS_D:  dcur_q <= clamp32(quo);
				DS_S2: begin
					s2mag_q <= quo[SW-1:0];
					s2neg_q <= dz2[16];
				end
				DS_S1: begin
					s1mag_q <= quo[SW-1:0];
					s1neg_q <= dz1[16];
				end
				DS_W1: w1_q <= quo[32:0];
				default: ;
			endcase
		end
		if (mul_done) begin
			case (mul_sel_q)
				MS_P1: p1_q <= prod[32 +: SW+1];
				MS_P2: p2_q <= prod[32 +: SW+1];
				MS_SQ: sq_q <= sat_shr(prod, 24);
				MS_T:  t_q  <= sat_shr(prod, FRAC_BITS);
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			if (seen_q == 2'd0 && !cmd.second) begin
				// single-point line
				chi_q   <= '0;
				eol_q   <= 1'b1;
				fault_q <= 1'b1;
			end else begin
				chi_q   <= emit_bad ? '1 : chi_calc;
				eol_q   <= cmd.second;
				fault_q <= emit_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = chi_q;
	assign m_tlast  = eol_q;
	assign m_tuser  = fault_q;

	always_comb begin
		sts           = '0;
		sts.zero_div  = (rho_q == '0) || (cp_q == '0);
		sts.last      = last_q;
		sts.h2_zero   = (h2 == '0);
		sts.first_bad = first_bad;
		sts.emit_bad  = emit_bad;
		sts.seen_zero = (seen_q == 2'd0);
		sts.seen_two  = (seen_q == 2'd2);
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.mul_busy  = mul_busy;
		sts.mul_done  = mul_done;
		sts.out_busy  = out_v_q && !m_tready;
	end

endmodule
`default_nettype wire

[rtl/scalar_dissipation_nonuniform_grid_unit.sv]
// Scalar dissipation rate along a streamed 1-D grid line.
// Each divide or multiply pass runs on the shared 64-step divider or
// multiplier; a point needs zero to eleven passes (none when a zero divisor
// faults the first point of a line), and points are taken one at a time.
// Results leave through an output register and hold there while m_tready is low.
// Reset (arst_n low) clears the line state and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module scalar_dissipation_nonuniform_grid_unit
	import sdn_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	// position, mix_fraction, conductivity, heat_capacity, density (low bit up)
	input  wire logic [IN_W-1:0] s_tdata,
	input  wire logic            s_tlast,   // last_point
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	// chi
	output logic [CHI_W-1:0]     m_tdata,
	output logic                 m_tlast,   // end_of_line
	output logic                 m_tuser    // fault
);

	cmd_t cmd;
	sts_t sts;

	sdn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdn_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
